[sv/pcsp_pkg.sv]
package pcsp_pkg;

	localparam int ByteW = 8;
	localparam int WordW = 16;
	localparam int PosW  = 4;
	localparam int FieldDepth = 16;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_OBJECT = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [WordW-1:0] ERR_TRUNCATED     = 16'd0;
	localparam logic [WordW-1:0] ERR_ZERO_DIM      = 16'd1;
	localparam logic [WordW-1:0] ERR_STATE         = 16'd2;
	localparam logic [WordW-1:0] ERR_HDR_RESERVED  = 16'd3;
	localparam logic [WordW-1:0] ERR_PALETTE_ID    = 16'd4;
	localparam logic [WordW-1:0] ERR_OBJECT_COUNT  = 16'd5;
	localparam logic [WordW-1:0] ERR_OBJ_RESERVED  = 16'd6;
	localparam logic [WordW-1:0] ERR_OUTSIDE_VIDEO = 16'd7;
	localparam logic [WordW-1:0] ERR_ZERO_CROP     = 16'd8;
	localparam logic [WordW-1:0] ERR_TRAILING      = 16'd9;

	localparam logic CFG_PALETTE_LIMIT = 1'b0;
	localparam logic CFG_OBJECT_LIMIT  = 1'b1;

	localparam logic [ByteW-1:0] PALETTE_LIMIT_RST = 8'd8;
	localparam logic [ByteW-1:0] OBJECT_LIMIT_RST  = 8'd2;

	localparam logic [PosW-1:0] HDR_LAST_POS  = 4'd10;
	localparam logic [PosW-1:0] OBJ_BASE_POS  = 4'd7;
	localparam logic [PosW-1:0] OBJ_CROP_POS  = 4'd15;

	typedef struct packed {
		logic [ByteW-1:0] palette_limit;
		logic [ByteW-1:0] object_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             done;
		logic [WordW-1:0] ident;
		logic [WordW-1:0] horiz;
		logic [WordW-1:0] vert;
		logic [WordW-1:0] aux_zero;
		logic [WordW-1:0] aux_one;
		logic [WordW-1:0] aux_two;
		logic [WordW-1:0] aux_three;
		logic [ByteW-1:0] small_id;
		logic [ByteW-1:0] flag_bits;
	} rec_t;

endpackage

[sv/pcsp_core.sv]
module pcsp_core import pcsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [ByteW-1:0] seg_byte,
	input  logic             seg_last,
	input  cfg_t             cfg,
	output logic             rec_valid,
	output rec_t             rec
);

	logic [PosW-1:0]  pos_q, pos_d;
	logic             in_obj_q, in_obj_d;
	logic [ByteW-1:0] left_q, left_d;
	logic             skip_q, skip_d;
	logic             parsed_q, parsed_d;
	logic [WordW-1:0] video_w_q, video_h_q;
	logic [ByteW-1:0] fb_q [FieldDepth];
	logic [ByteW-1:0] fb_cur [FieldDepth];

	logic             video_we;
	logic             fb_we;
	logic             do_fail;
	logic             do_end;
	logic             obj_done;
	logic             cropped;
	logic [WordW-1:0] fail_code;
	logic [WordW-1:0] hdr_w, hdr_h, obj_x, obj_y;
	logic [WordW-1:0] crop_x, crop_y, crop_w, crop_h;
	logic [ByteW-1:0] st, pu, pal, cnt, ofl;

	always_comb begin
		fb_cur = fb_q;
		fb_cur[pos_q] = seg_byte;
	end

	assign hdr_w  = {fb_cur[0], fb_cur[1]};
	assign hdr_h  = {fb_cur[2], fb_cur[3]};
	assign st     = fb_cur[7];
	assign pu     = fb_cur[8];
	assign pal    = fb_cur[9];
	assign cnt    = fb_cur[10];
	assign ofl    = fb_cur[3];
	assign obj_x  = {fb_cur[4], fb_cur[5]};
	assign obj_y  = {fb_cur[6], fb_cur[7]};
	assign crop_x = {fb_cur[8], fb_cur[9]};
	assign crop_y = {fb_cur[10], fb_cur[11]};
	assign crop_w = {fb_cur[12], fb_cur[13]};
	assign crop_h = {fb_cur[14], fb_cur[15]};
	assign cropped = (pos_q == OBJ_CROP_POS);

	always_comb begin
		pos_d     = pos_q;
		in_obj_d  = in_obj_q;
		left_d    = left_q;
		skip_d    = skip_q;
		parsed_d  = parsed_q;
		video_we  = 1'b0;
		fb_we     = 1'b0;
		do_fail   = 1'b0;
		do_end    = 1'b0;
		obj_done  = 1'b0;
		fail_code = ERR_TRUNCATED;
		rec_valid = 1'b0;
		rec       = '0;
		rec.done  = seg_last;

		if (skip_q) begin
			do_end = seg_last;
		end else if (parsed_q) begin
			do_fail   = 1'b1;
			fail_code = ERR_TRAILING;
		end else if (!in_obj_q) begin
			fb_we = 1'b1;
			if (pos_q != HDR_LAST_POS) begin
				if (seg_last) do_fail = 1'b1;
				else pos_d = pos_q + 1'b1;
			end else begin
				video_we = 1'b1;
				if (hdr_w == '0 || hdr_h == '0) begin
					do_fail = 1'b1; fail_code = ERR_ZERO_DIM;
				end else if (st[5:0] != '0) begin
					do_fail = 1'b1; fail_code = ERR_STATE;
				end else if (pu[6:0] != '0) begin
					do_fail = 1'b1; fail_code = ERR_HDR_RESERVED;
				end else if (pal >= cfg.palette_limit) begin
					do_fail = 1'b1; fail_code = ERR_PALETTE_ID;
				end else if (cnt > cfg.object_limit) begin
					do_fail = 1'b1; fail_code = ERR_OBJECT_COUNT;
				end else if (cnt != '0 && seg_last) begin
					do_fail = 1'b1;
				end else begin
					rec_valid      = 1'b1;
					rec.kind       = KIND_HEADER;
					rec.ident      = {fb_cur[5], fb_cur[6]};
					rec.horiz      = hdr_w;
					rec.vert       = hdr_h;
					rec.aux_zero   = {8'h00, pal};
					rec.aux_one    = {8'h00, cnt};
					rec.small_id   = fb_cur[4];
					rec.flag_bits  = {st[7:6], pu[7], (st != '0), 4'b0000};
					pos_d = '0;
					if (cnt == '0) begin
						if (seg_last) do_end = 1'b1;
						else parsed_d = 1'b1;
					end else begin
						in_obj_d = 1'b1;
						left_d   = cnt;
					end
				end
			end
		end else begin
			fb_we = 1'b1;
			if (pos_q == OBJ_BASE_POS) begin
				if (ofl[5:0] != '0) begin
					do_fail = 1'b1; fail_code = ERR_OBJ_RESERVED;
				end else if (obj_x > video_w_q || obj_y > video_h_q) begin
					do_fail = 1'b1; fail_code = ERR_OUTSIDE_VIDEO;
				end else if (ofl[7]) begin
					if (seg_last) do_fail = 1'b1;
					else pos_d = pos_q + 1'b1;
				end else begin
					obj_done = 1'b1;
				end
			end else if (cropped) begin
				obj_done = 1'b1;
			end else begin
				if (seg_last) do_fail = 1'b1;
				else pos_d = pos_q + 1'b1;
			end
		end

		if (obj_done) begin
			if (cropped && (crop_w == '0 || crop_h == '0)) begin
				do_fail = 1'b1; fail_code = ERR_ZERO_CROP;
			end else if (left_q > 8'd1 && seg_last) begin
				do_fail = 1'b1;
			end else begin
				rec_valid     = 1'b1;
				rec.kind      = KIND_OBJECT;
				rec.ident     = {fb_cur[0], fb_cur[1]};
				rec.horiz     = obj_x;
				rec.vert      = obj_y;
				rec.aux_zero  = cropped ? crop_x : '0;
				rec.aux_one   = cropped ? crop_y : '0;
				rec.aux_two   = cropped ? crop_w : '0;
				rec.aux_three = cropped ? crop_h : '0;
				rec.small_id  = fb_cur[2];
				rec.flag_bits = ofl;
				pos_d  = '0;
				left_d = left_q - 1'b1;
				if (left_q == 8'd1) begin
					if (seg_last) begin
						do_end = 1'b1;
					end else begin
						in_obj_d = 1'b0;
						parsed_d = 1'b1;
					end
				end
			end
		end

		if (do_fail) begin
			rec_valid = 1'b1;
			rec       = '0;
			rec.kind  = KIND_ERROR;
			rec.done  = seg_last;
			rec.ident = fail_code;
			if (seg_last) do_end = 1'b1;
			else skip_d = 1'b1;
		end

		if (do_end) begin
			pos_d    = '0;
			in_obj_d = 1'b0;
			left_d   = '0;
			skip_d   = 1'b0;
			parsed_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			in_obj_q  <= 1'b0;
			left_q    <= '0;
			skip_q    <= 1'b0;
			parsed_q  <= 1'b0;
			video_w_q <= '0;
			video_h_q <= '0;
		end else if (fire) begin
			pos_q    <= pos_d;
			in_obj_q <= in_obj_d;
			left_q   <= left_d;
			skip_q   <= skip_d;
			parsed_q <= parsed_d;
			if (video_we) begin
				video_w_q <= hdr_w;
				video_h_q <= hdr_h;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && fb_we) begin
			fb_q[pos_q] <= seg_byte;
		end
	end

	a_parsed_not_obj: assert property (@(posedge clk) disable iff (!arst_n)
		parsed_q |-> !in_obj_q)
		else $error("all-parsed set during object phase");

	a_obj_owed: assert property (@(posedge clk) disable iff (!arst_n)
		in_obj_q |-> (left_q != '0))
		else $error("object phase with nothing owed");

	a_hdr_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!in_obj_q |-> (pos_q <= HDR_LAST_POS))
		else $error("header position beyond last header byte");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && seg_last) |=> (pos_q == '0 && !in_obj_q && !skip_q && !parsed_q))
		else $error("parse state not restarted after final byte");

endmodule

[sv/subtitle_composition_segment_parser_top.sv]
// subtitle composition segment parser
//
// bytes of a composition segment body enter on the in channel (in_valid /
// in_ready, seg_byte, seg_last marks the final byte of each segment). header,
// object and error records leave on the out channel (out_valid / out_ready)
// as one word each; bytes that complete no record give no word. the user must
// write palette_limit and object_limit through cfg_wr_en / cfg_index /
// cfg_data, and only while the block is idle; the block itself has no guard.
//
// a byte accepted into the input register is parsed from it combinationally
// and its record is registered in the output register as the parser advances.
// throughput: one byte per cycle unless stalled; the state carried from byte
// to byte is the parse position, phase flags, objects owed, stored video size
// and capture bytes. when the receiver stalls the record waits in the output
// register; the input register still takes one more byte, and in_ready falls
// only when both are full. reset clears the parse state, the stored video
// size and the output valid, and loads the default limits (8 and 2).
module subtitle_composition_segment_parser_top import pcsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] seg_byte,
	input  logic             seg_last,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       rec_kind,
	output logic             seg_done,
	output logic [WordW-1:0] ident,
	output logic [WordW-1:0] horiz,
	output logic [WordW-1:0] vert,
	output logic [WordW-1:0] aux_zero,
	output logic [WordW-1:0] aux_one,
	output logic [WordW-1:0] aux_two,
	output logic [WordW-1:0] aux_three,
	output logic [ByteW-1:0] small_id,
	output logic [ByteW-1:0] flag_bits,
	input  logic             cfg_wr_en,
	input  logic             cfg_index,
	input  logic [ByteW-1:0] cfg_data
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             last_s1;
	logic             advance;
	cfg_t             cfg_q;
	logic             core_valid;
	rec_t             core_rec;
	logic             out_valid_q;
	rec_t             rec_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= seg_byte;
			last_s1 <= seg_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.palette_limit <= PALETTE_LIMIT_RST;
			cfg_q.object_limit  <= OBJECT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PALETTE_LIMIT: cfg_q.palette_limit <= cfg_data;
				CFG_OBJECT_LIMIT:  cfg_q.object_limit  <= cfg_data;
				default: ;
			endcase
		end
	end

	pcsp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.seg_byte  (byte_s1),
		.seg_last  (last_s1),
		.cfg       (cfg_q),
		.rec_valid (core_valid),
		.rec       (core_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= core_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			rec_q <= core_rec;
		end
	end

	assign out_valid = out_valid_q;
	assign rec_kind  = rec_q.kind;
	assign seg_done  = rec_q.done;
	assign ident     = rec_q.ident;
	assign horiz     = rec_q.horiz;
	assign vert      = rec_q.vert;
	assign aux_zero  = rec_q.aux_zero;
	assign aux_one   = rec_q.aux_one;
	assign aux_two   = rec_q.aux_two;
	assign aux_three = rec_q.aux_three;
	assign small_id  = rec_q.small_id;
	assign flag_bits = rec_q.flag_bits;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !advance)
		else $error("held word overwritten by parser");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input refused with empty input register");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rec_q.kind == KIND_ERROR) |->
		(rec_q.horiz == '0 && rec_q.vert == '0 && rec_q.flag_bits == '0))
		else $error("error word carries payload");

endmodule
